// ----- sv/fnr_pkg.sv -----
`timescale 1ns / 1ps
package fnr_pkg;

    localparam int WIDTH = 32;

    typedef struct packed {
        logic signed [WIDTH-1:0] numerator;
        logic signed [WIDTH-1:0] denominator;
    } t_fnr_in;

    typedef struct packed {
        logic             negative;
        logic [WIDTH-1:0] reduced_numerator;
        logic [WIDTH-1:0] reduced_denominator;
        logic             zero_denominator;
    } t_fnr_out;

    // One beat moving along the divider chain.
    typedef struct packed {
        logic             vld;
        logic [WIDTH-1:0] rem;
        logic [WIDTH-1:0] dvd;
        logic [WIDTH-1:0] dsr;
        logic [WIDTH-1:0] quo;
    } t_div_beat;

endpackage

// ----- sv/fraction_normalize_reduce_core.sv -----
`timescale 1ns / 1ps
// Each divide pass runs through the row of 32 divider cells. An item takes
// k + 2 passes, where k is the number of Euclid remainder steps (k <= 47
// at 32 bits); a zero denominator skips the divider row. One item is in
// work at a time; the output register lets the next item enter while a
// result waits. Reset (synchronous, active low) empties the divider row
// and the output register and returns to idle.
module fraction_normalize_reduce_core
    import fnr_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_fnr_in  i_in_data,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    output t_fnr_out o_out_data
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_GCD   = 6'b000010,
        S_GWAIT = 6'b000100,
        S_DIVN  = 6'b001000,
        S_DIVD  = 6'b010000,
        S_FIN   = 6'b100000
    } t_state;

    t_state           r_state;
    t_state           n_state;
    logic [WIDTH-1:0] r_nmag;
    logic [WIDTH-1:0] r_dmag;
    logic [WIDTH-1:0] r_a;
    logic [WIDTH-1:0] r_b;
    t_fnr_out         r_res;
    t_fnr_out         r_out;
    logic             r_out_vld;
    logic             w_accept;
    logic [WIDTH-1:0] w_nmag;
    logic [WIDTH-1:0] w_dmag;
    t_div_beat        w_chain [0:WIDTH];

    assign w_accept = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);
    assign w_nmag = i_in_data.numerator[WIDTH-1] ? (~i_in_data.numerator + 1'b1)
                                                 : i_in_data.numerator;
    assign w_dmag = i_in_data.denominator[WIDTH-1] ? (~i_in_data.denominator + 1'b1)
                                                   : i_in_data.denominator;

    // Feed the head of the row.
    always_comb begin
        w_chain[0].vld = 1'b0;
        w_chain[0].rem = '0;
        w_chain[0].dvd = r_a;
        w_chain[0].dsr = r_b;
        w_chain[0].quo = '0;
        unique case (r_state)
            S_GCD: begin
                w_chain[0].vld = (r_b != '0);
                if (r_b == '0) begin
                    w_chain[0].vld = 1'b1;
                    w_chain[0].dvd = r_nmag;
                    w_chain[0].dsr = r_a;
                end
            end
            S_DIVN: begin
                w_chain[0].vld = w_chain[WIDTH].vld;
                w_chain[0].dvd = r_dmag;
                w_chain[0].dsr = r_a;
            end
            default: begin
                w_chain[0].vld = 1'b0;
            end
        endcase
    end

    genvar gi;
    generate
        for (gi = 0; gi < WIDTH; gi++) begin : g_cell
            fnr_cell u_cell (
                .i_clk  (i_clk),
                .i_rst_n(i_rst_n),
                .i_beat (w_chain[gi]),
                .o_beat (w_chain[gi+1])
            );
        end
    endgenerate

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_in_valid) n_state = (w_dmag == '0) ? S_FIN : S_GCD;
            S_GCD:   n_state = (r_b == '0) ? S_DIVN : S_GWAIT;
            S_GWAIT: if (w_chain[WIDTH].vld) n_state = S_GCD;
            S_DIVN:  if (w_chain[WIDTH].vld) n_state = S_DIVD;
            S_DIVD:  if (w_chain[WIDTH].vld) n_state = S_FIN;
            S_FIN:   if (!r_out_vld || !i_out_stall) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_nmag <= w_nmag;
            r_dmag <= w_dmag;
            r_a    <= w_nmag;
            r_b    <= w_dmag;
            r_res.negative <= (w_dmag != '0) &&
                (i_in_data.numerator[WIDTH-1] ^ i_in_data.denominator[WIDTH-1]);
            r_res.zero_denominator    <= (w_dmag == '0);
            r_res.reduced_numerator   <= '0;
            r_res.reduced_denominator <= '0;
        end
        if (r_state == S_GWAIT && w_chain[WIDTH].vld) begin
            r_a <= r_b;
            r_b <= w_chain[WIDTH].rem;
        end
        if (r_state == S_DIVN && w_chain[WIDTH].vld) begin
            r_res.reduced_numerator <= w_chain[WIDTH].quo;
        end
        if (r_state == S_DIVD && w_chain[WIDTH].vld) begin
            r_res.reduced_denominator <= w_chain[WIDTH].quo;
        end
        if (r_state == S_FIN && (!r_out_vld || !i_out_stall)) begin
            r_out <= r_res;
        end
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_FIN && (!r_out_vld || !i_out_stall)) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule

// ----- sv/fnr_cell.sv -----
`timescale 1ns / 1ps
module fnr_cell
    import fnr_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_div_beat i_beat,
    output t_div_beat o_beat
);

    t_div_beat        r_beat;
    t_div_beat        n_beat;
    logic [WIDTH:0]   w_trial;
    logic [WIDTH:0]   w_diff;
    logic             w_ge;

    // One restoring division step: bring in the next dividend bit and
    // subtract the divisor when it fits.
    always_comb begin
        w_trial = {i_beat.rem, i_beat.dvd[WIDTH-1]};
        w_diff  = w_trial - {1'b0, i_beat.dsr};
        w_ge    = (w_trial >= {1'b0, i_beat.dsr});
        n_beat.vld = i_beat.vld;
        n_beat.rem = w_ge ? w_diff[WIDTH-1:0] : w_trial[WIDTH-1:0];
        n_beat.dvd = {i_beat.dvd[WIDTH-2:0], 1'b0};
        n_beat.dsr = i_beat.dsr;
        n_beat.quo = {i_beat.quo[WIDTH-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        r_beat.rem <= n_beat.rem;
        r_beat.dvd <= n_beat.dvd;
        r_beat.dsr <= n_beat.dsr;
        r_beat.quo <= n_beat.quo;
        if (!i_rst_n) begin
            r_beat.vld <= 1'b0;
        end else begin
            r_beat.vld <= n_beat.vld;
        end
    end

    assign o_beat = r_beat;

endmodule

// ----- sv/fnr_checker.sv -----
`timescale 1ns / 1ps
module fnr_checker
    import fnr_pkg::*;
(
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     i_in_valid,
    input logic     o_in_stall,
    input logic     o_out_valid,
    input logic     i_out_stall,
    input t_fnr_out o_out_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled output beat changed");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken again before the item finished");

    a_den_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.zero_denominator |->
            o_out_data.reduced_denominator != '0)
        else $error("reduced denominator is zero on a valid fraction");

    a_error_zeros: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.zero_denominator |->
            o_out_data.reduced_numerator == '0 &&
            o_out_data.reduced_denominator == '0 && !o_out_data.negative)
        else $error("error beat carries nonzero fields");

endmodule

bind fraction_normalize_reduce_core fnr_checker u_fnr_checker (.*);
